FILE: rtl/tti_pkg.sv
// shared types, constants and the character decode for the text to integer parser
// no dependencies; used by every rtl file through scoped names
package tti_pkg;

   localparam int CHR_W    = 8;
   localparam int VALUE_W  = 64;
   localparam int OFFSET_W = 12;
   localparam int STATUS_W = 2;
   localparam int BASE_W   = 6;
   localparam int DIGIT_W  = 7;
   localparam int ADDR_W   = 5;

   localparam logic [CHR_W-1:0] CHR_NUL     = 8'h00;
   localparam logic [CHR_W-1:0] CHR_NEWLINE = 8'h0A;
   localparam logic [CHR_W-1:0] CHR_SPACE   = 8'h20;
   localparam logic [CHR_W-1:0] CHR_PLUS    = 8'h2B;
   localparam logic [CHR_W-1:0] CHR_MINUS   = 8'h2D;
   localparam logic [CHR_W-1:0] CHR_ZERO    = 8'h30;
   localparam logic [CHR_W-1:0] CHR_NINE    = 8'h39;
   localparam logic [CHR_W-1:0] CHR_UP_A    = 8'h41;
   localparam logic [CHR_W-1:0] CHR_UP_Z    = 8'h5A;
   localparam logic [CHR_W-1:0] CHR_UP_X    = 8'h58;
   localparam logic [CHR_W-1:0] CHR_LO_A    = 8'h61;
   localparam logic [CHR_W-1:0] CHR_LO_Z    = 8'h7A;
   localparam logic [CHR_W-1:0] CHR_LO_X    = 8'h78;

   localparam logic [DIGIT_W-1:0] NO_DIGIT = 7'd99;

   localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
   localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
   localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BLANK = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   localparam logic [1:0] REG_BASE   = 2'd0;
   localparam logic [1:0] REG_SIGNED = 2'd1;
   localparam logic [1:0] REG_LIMIT  = 2'd2;

   localparam logic [VALUE_W-1:0] LIMIT_RESET = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      BSEL_REQ,
      BSEL_OCT,
      BSEL_DEC,
      BSEL_HEX
   } base_sel_type;

   typedef struct packed {
      logic         load_chr;
      logic         set_sign;
      logic         start_div;
      base_sel_type base_sel;
      logic         take_digit;
      logic         stop;
      logic         advance;
      logic         emit;
      logic         emit_blank;
      logic         emit_stopped;
   } cmd_type;

   typedef struct packed {
      logic chr_zero;
      logic chr_space;
      logic chr_sign;
      logic chr_digit0;
      logic chr_x;
      logic req_auto;
      logic req_hex;
      logic req_oct;
      logic signed_mode;
      logic digit_end;
      logic div_done;
      logic out_free;
   } status_type;

   // digit value of a byte in any radix up to 36, NO_DIGIT otherwise
   function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHR_W-1:0] c);
      logic [CHR_W-1:0] d;
      d = CHR_NUL;
      if (c >= CHR_ZERO && c <= CHR_NINE) begin
         d = c - CHR_ZERO;
         return DIGIT_W'(d);
      end
      if (c >= CHR_UP_A && c <= CHR_UP_Z) begin
         d = c - CHR_UP_A + 8'd10;
         return DIGIT_W'(d);
      end
      if (c >= CHR_LO_A && c <= CHR_LO_Z) begin
         d = c - CHR_LO_A + 8'd10;
         return DIGIT_W'(d);
      end
      return NO_DIGIT;
   endfunction

endpackage

FILE: rtl/tti_divider.sv
// restoring divider: 64-bit limit by a small radix, one quotient bit per cycle
// depends on tti_pkg for widths
module tti_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tti_pkg::VALUE_W-1:0]      dividend,
   input  logic [tti_pkg::BASE_W-1:0]       divisor,
   output logic                             done,
   output logic [tti_pkg::VALUE_W-1:0]      quotient,
   output logic [tti_pkg::BASE_W-1:0]       remainder
);

   localparam int CNT_W = $clog2(tti_pkg::VALUE_W);

   logic                          busy_ff, busy_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [tti_pkg::VALUE_W-1:0]   quo_ff, quo_in;
   logic [tti_pkg::BASE_W-1:0]    rem_ff, rem_in;
   logic [tti_pkg::BASE_W-1:0]    div_ff, div_in;
   logic [tti_pkg::BASE_W:0]      trial;
   logic                          fits;

   assign trial = {rem_ff, quo_ff[tti_pkg::VALUE_W-1]};
   assign fits  = trial >= {1'b0, div_ff};
   assign done  = busy_ff && (cnt_ff == '0);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(tti_pkg::VALUE_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // dividend bits shift out the top while quotient bits enter the bottom
         quo_in = {quo_ff[tti_pkg::VALUE_W-2:0], fits};
         rem_in = fits ? tti_pkg::BASE_W'(trial - {1'b0, div_ff})
                       : tti_pkg::BASE_W'(trial);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   assert property (@(posedge clock) disable iff (reset)
      busy_ff && !done && !start |=> busy_ff)
      else $error("divider dropped busy before last bit");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < div_ff)
      else $error("partial remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && cnt_ff == CNT_W'(tti_pkg::VALUE_W - 1))
      else $error("divider did not load on start");

endmodule

FILE: rtl/tti_datapath.sv
// datapath: byte register, accumulator, string state, limit divider and result register
// depends on tti_pkg and tti_divider
module tti_datapath #(
   parameter int OFFSET_LIMIT = 4095
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tti_pkg::cmd_type                   cmd,
   output tti_pkg::status_type                status,
   input  logic [tti_pkg::CHR_W-1:0]          chr,
   input  logic [tti_pkg::BASE_W-1:0]         base_request,
   input  logic                               signed_mode,
   input  logic [tti_pkg::VALUE_W-1:0]        limit,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tti_pkg::VALUE_W-1:0]        rsp_value,
   output logic [tti_pkg::OFFSET_W-1:0]       rsp_stop_offset,
   output logic [tti_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int POS_W = $clog2(OFFSET_LIMIT + 1);
   localparam int EXT_W = (POS_W > tti_pkg::OFFSET_W) ? POS_W : tti_pkg::OFFSET_W;
   localparam int PROD_W = tti_pkg::VALUE_W + tti_pkg::BASE_W;

   logic [tti_pkg::CHR_W-1:0]     chr_ff;
   logic [tti_pkg::VALUE_W-1:0]   accum_ff, accum_in;
   logic                          neg_ff, neg_in;
   logic [tti_pkg::BASE_W-1:0]    base_ff, base_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [POS_W-1:0]              stop_ff, stop_in;
   logic [tti_pkg::STATUS_W-1:0]  stat_ff, stat_in;

   logic                          rsp_valid_ff;
   logic [tti_pkg::VALUE_W-1:0]   rsp_value_ff;
   logic [tti_pkg::OFFSET_W-1:0]  rsp_offset_ff;
   logic [tti_pkg::STATUS_W-1:0]  rsp_status_ff;

   logic [tti_pkg::BASE_W-1:0]    div_base;
   logic                          div_done;
   logic [tti_pkg::VALUE_W-1:0]   qlim;
   logic [tti_pkg::BASE_W-1:0]    rlim;

   logic [tti_pkg::DIGIT_W-1:0]   dval;
   logic [tti_pkg::DIGIT_W-1:0]   thr;
   logic                          digit_ok;
   logic                          ovf;
   logic [PROD_W-1:0]             prod;
   logic [tti_pkg::VALUE_W-1:0]   accum_next;
   logic                          req_ok;

   logic [tti_pkg::VALUE_W-1:0]   out_value;
   logic [POS_W-1:0]              out_pos;
   logic [EXT_W-1:0]              out_pos_ext;

   always_comb begin
      unique case (cmd.base_sel)
         tti_pkg::BSEL_REQ: div_base = base_request;
         tti_pkg::BSEL_OCT: div_base = tti_pkg::BASE_OCT;
         tti_pkg::BSEL_DEC: div_base = tti_pkg::BASE_DEC;
         tti_pkg::BSEL_HEX: div_base = tti_pkg::BASE_HEX;
         default:           div_base = tti_pkg::BASE_DEC;
      endcase
   end

   tti_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_div),
      .dividend  (limit),
      .divisor   (div_base),
      .done      (div_done),
      .quotient  (qlim),
      .remainder (rlim)
   );

   // one digit step: compare against limit / base, then multiply-accumulate
   assign dval       = tti_pkg::digit_of(chr_ff);
   assign digit_ok   = {1'b0, base_ff} > dval;
   assign thr        = {1'b0, rlim} + {{(tti_pkg::DIGIT_W-1){1'b0}}, neg_ff};
   assign ovf        = (accum_ff > qlim) || ((accum_ff == qlim) && (dval > thr));
   assign prod       = {{tti_pkg::BASE_W{1'b0}}, accum_ff}
                     * {{tti_pkg::VALUE_W{1'b0}}, base_ff};
   assign accum_next = prod[tti_pkg::VALUE_W-1:0]
                     + {{(tti_pkg::VALUE_W-tti_pkg::DIGIT_W){1'b0}}, dval};

   assign req_ok = (base_request >= tti_pkg::BASE_MIN) && (base_request <= tti_pkg::BASE_MAX);

   always_comb begin
      status.chr_zero    = chr_ff == tti_pkg::CHR_NUL;
      status.chr_space   = (chr_ff == tti_pkg::CHR_SPACE) || (chr_ff == tti_pkg::CHR_NEWLINE);
      status.chr_sign    = (chr_ff == tti_pkg::CHR_PLUS) || (chr_ff == tti_pkg::CHR_MINUS);
      status.chr_digit0  = chr_ff == tti_pkg::CHR_ZERO;
      status.chr_x       = (chr_ff == tti_pkg::CHR_LO_X) || (chr_ff == tti_pkg::CHR_UP_X);
      status.req_auto    = !req_ok;
      status.req_hex     = base_request == tti_pkg::BASE_HEX;
      status.req_oct     = base_request == tti_pkg::BASE_OCT;
      status.signed_mode = signed_mode;
      status.digit_end   = !digit_ok || ovf;
      status.div_done    = div_done;
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      accum_in = accum_ff;
      neg_in   = neg_ff;
      base_in  = base_ff;
      pos_in   = pos_ff;
      stop_in  = stop_ff;
      stat_in  = stat_ff;
      if (cmd.emit) begin
         accum_in = '0;
         neg_in   = 1'b0;
         base_in  = '0;
         pos_in   = '0;
         stop_in  = '0;
         stat_in  = tti_pkg::STAT_OK;
      end else begin
         if (cmd.set_sign) begin
            neg_in = chr_ff == tti_pkg::CHR_MINUS;
         end
         if (cmd.start_div) begin
            base_in = div_base;
         end
         if (cmd.stop) begin
            stop_in = pos_ff;
         end
         if (cmd.take_digit) begin
            if (!digit_ok) begin
               stop_in = pos_ff;
            end else if (ovf) begin
               // saturate to the limit, or to its complement when negative
               accum_in = neg_ff ? ~limit : limit;
               neg_in   = 1'b0;
               stat_in  = tti_pkg::STAT_RANGE;
               stop_in  = pos_ff;
            end else begin
               accum_in = accum_next;
            end
         end
         if (cmd.advance && (pos_ff < POS_W'(OFFSET_LIMIT))) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         neg_ff   <= 1'b0;
         base_ff  <= '0;
         pos_ff   <= '0;
         stop_ff  <= '0;
         stat_ff  <= tti_pkg::STAT_OK;
      end else begin
         accum_ff <= accum_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
         pos_ff   <= pos_in;
         stop_ff  <= stop_in;
         stat_ff  <= stat_in;
      end
   end

   assign out_value   = neg_ff ? (~accum_ff + 1'b1) : accum_ff;
   assign out_pos     = cmd.emit_stopped ? stop_ff : pos_ff;
   assign out_pos_ext = EXT_W'(out_pos);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_chr) begin
         chr_ff <= chr;
      end
      if (cmd.emit) begin
         rsp_value_ff  <= cmd.emit_blank ? '0 : out_value;
         rsp_status_ff <= cmd.emit_blank ? tti_pkg::STAT_BLANK : stat_ff;
         rsp_offset_ff <= out_pos_ext[tti_pkg::OFFSET_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_stop_offset = rsp_offset_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

FILE: rtl/tti_ctrl.sv
// controller: item sequencing and parse phase, drives datapath commands
// depends on tti_pkg
module tti_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tti_pkg::status_type   status,
   output tti_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_DIGIT,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      digit_after_ff, digit_after_in;
   logic      ready_ff;
   logic      begin_num;

   // first byte of the number proper, after whitespace and an optional sign
   assign begin_num = (phase_ff == PH_SIGNED)
                   || ((phase_ff == PH_SKIP) && !status.chr_space
                       && !(status.chr_sign && status.signed_mode));

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      digit_after_in = digit_after_ff;
      cmd            = '0;
      cmd.base_sel   = tti_pkg::BSEL_DEC;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load_chr = 1'b1;
               state_in     = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.chr_zero) begin
               state_in = ST_EMIT;
            end else if (begin_num) begin
               if (status.chr_digit0) begin
                  phase_in    = PH_ZERO;
                  cmd.advance = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  cmd.start_div  = 1'b1;
                  cmd.base_sel   = status.req_auto ? tti_pkg::BSEL_DEC : tti_pkg::BSEL_REQ;
                  digit_after_in = 1'b1;
                  phase_in       = PH_DIGITS;
                  state_in       = ST_DIV;
               end
            end else begin
               unique case (phase_ff)
                  PH_SKIP: begin
                     if (!status.chr_space) begin
                        cmd.set_sign = 1'b1;
                        phase_in     = PH_SIGNED;
                     end
                     cmd.advance = 1'b1;
                     state_in    = ST_IDLE;
                  end
                  PH_ZERO: begin
                     if (status.chr_x) begin
                        if (status.req_auto || status.req_hex) begin
                           cmd.start_div  = 1'b1;
                           cmd.base_sel   = tti_pkg::BSEL_HEX;
                           digit_after_in = 1'b0;
                           phase_in       = PH_DIGITS;
                           state_in       = ST_DIV;
                        end else begin
                           cmd.stop    = 1'b1;
                           cmd.advance = 1'b1;
                           phase_in    = PH_DONE;
                           state_in    = ST_IDLE;
                        end
                     end else begin
                        // leading zero means octal in automatic mode
                        cmd.start_div  = 1'b1;
                        cmd.base_sel   = (status.req_auto || status.req_oct)
                                       ? tti_pkg::BSEL_OCT : tti_pkg::BSEL_REQ;
                        digit_after_in = 1'b1;
                        phase_in       = PH_DIGITS;
                        state_in       = ST_DIV;
                     end
                  end
                  PH_DIGITS: begin
                     state_in = ST_DIGIT;
                  end
                  default: begin
                     cmd.advance = 1'b1;
                     state_in    = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               if (digit_after_ff) begin
                  state_in = ST_DIGIT;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_DIGIT: begin
            cmd.take_digit = 1'b1;
            cmd.advance    = 1'b1;
            if (status.digit_end) begin
               phase_in = PH_DONE;
            end
            state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit         = 1'b1;
               cmd.emit_blank   = phase_ff == PH_SKIP;
               cmd.emit_stopped = phase_ff == PH_DONE;
               phase_in         = PH_SKIP;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_SKIP;
         digit_after_ff <= 1'b0;
         ready_ff       <= 1'b1;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         digit_after_ff <= digit_after_in;
         ready_ff       <= state_in == ST_IDLE;
      end
   end

   assign in_ready = ready_ff;

   assert property (@(posedge clock) disable iff (reset)
      ready_ff == (state_ff == ST_IDLE))
      else $error("ready out of step with controller state");

   assert property (@(posedge clock) disable iff (reset)
      in_valid && ready_ff |=> state_ff == ST_EVAL)
      else $error("accepted item not evaluated");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGIT |-> phase_ff == PH_DIGITS)
      else $error("digit step outside digit phase");

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free && status.chr_zero)
      else $error("result written without free slot or end byte");

endmodule

FILE: rtl/text_to_integer_parser.sv
// Text to integer parser, top level: configuration registers, controller and datapath.
// Depends on tti_pkg, tti_ctrl, tti_datapath and tti_divider.
//
// Usage: the string arrives one byte per item on the req_ channel, ended by a
// zero byte. Leading spaces and newlines are skipped, an optional sign (signed
// mode) and a 0x or leading-zero prefix follow, then digits of the base. The
// zero byte produces one rsp_ item: value, stop offset and status.
// Steps: whitespace, sign and prefix bytes, and bytes after the number has
// ended, are evaluated and taken; a digit byte also gets a digit step. The
// byte that fixes the base also runs the limit / base divider, one quotient
// bit per cycle, before its digit step, or before the next byte for the x of
// a 0x prefix. The zero byte waits until the output register is free.
// The result sits in an output register; a stalled receiver only delays the
// next zero byte, other bytes keep being taken.
// Configuration: APB-style port, 64-bit data, register i at byte address 8*i
// (base_request, signed_mode, limit). Write between strings or between bytes
// while no item is in work.
// Reset: synchronous, restores the register defaults (automatic base, signed,
// limit 2^63-1) and starts a fresh string; there is no clearing pass.
module text_to_integer_parser #(
   parameter int OFFSET_LIMIT = 4095
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tti_pkg::CHR_W-1:0]          req_chr,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tti_pkg::VALUE_W-1:0]        rsp_value,
   output logic [tti_pkg::OFFSET_W-1:0]       rsp_stop_offset,
   output logic [tti_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tti_pkg::ADDR_W-1:0]         csr_paddr,
   input  logic [tti_pkg::VALUE_W-1:0]        csr_pwdata,
   output logic [tti_pkg::VALUE_W-1:0]        csr_prdata,
   output logic                               csr_pready
);

   logic [tti_pkg::BASE_W-1:0]   base_request_ff;
   logic                         signed_mode_ff;
   logic [tti_pkg::VALUE_W-1:0]  limit_ff;
   logic                         csr_write;
   logic [1:0]                   csr_index;

   tti_pkg::cmd_type             cmd;
   tti_pkg::status_type          status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[tti_pkg::ADDR_W-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_request_ff <= '0;
         signed_mode_ff  <= 1'b1;
         limit_ff        <= tti_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            tti_pkg::REG_BASE:   base_request_ff <= csr_pwdata[tti_pkg::BASE_W-1:0];
            tti_pkg::REG_SIGNED: signed_mode_ff  <= csr_pwdata[0];
            tti_pkg::REG_LIMIT:  limit_ff        <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         tti_pkg::REG_BASE:
            csr_prdata = {{(tti_pkg::VALUE_W-tti_pkg::BASE_W){1'b0}}, base_request_ff};
         tti_pkg::REG_SIGNED:
            csr_prdata = {{(tti_pkg::VALUE_W-1){1'b0}}, signed_mode_ff};
         tti_pkg::REG_LIMIT:
            csr_prdata = limit_ff;
         default:
            csr_prdata = '0;
      endcase
   end

   tti_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   tti_datapath #(
      .OFFSET_LIMIT (OFFSET_LIMIT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .chr             (req_chr),
      .base_request    (base_request_ff),
      .signed_mode     (signed_mode_ff),
      .limit           (limit_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_stop_offset (rsp_stop_offset),
      .rsp_status      (rsp_status)
   );

endmodule

FILE: dv/text_to_integer_parser_tb.sv
// testbench for text_to_integer_parser: strings go in one byte per item, and each parse result
// is checked against a cycle-free byte scanner kept in this file
// depends on tti_pkg and the rtl of text_to_integer_parser
module text_to_integer_parser_tb;

   localparam int unsigned OFFSET_TOP    = 4095;
   localparam int unsigned IDLE_MAX      = 14;
   localparam int unsigned SETTLE_CYCLES = 100;
   localparam int unsigned CYCLE_LIMIT   = 3_000_000;
   localparam int unsigned NOT_A_DIGIT   = 99;
   localparam int unsigned LONG_BLANKS   = 256;
   localparam int unsigned PHASE_BYTES   = 40;
   localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      SCAN_SKIP,
      SCAN_SIGN,
      SCAN_ZERO,
      SCAN_DIGITS,
      SCAN_DONE
   } scan_phase_type;

   typedef struct packed {
      logic [tti_pkg::VALUE_W-1:0]  value;
      logic [tti_pkg::OFFSET_W-1:0] offset;
      logic [tti_pkg::STATUS_W-1:0] status;
   } number_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [tti_pkg::CHR_W-1:0]    req_chr = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [tti_pkg::VALUE_W-1:0]  rsp_value;
   logic [tti_pkg::OFFSET_W-1:0] rsp_stop_offset;
   logic [tti_pkg::STATUS_W-1:0] rsp_status;
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [tti_pkg::ADDR_W-1:0]   csr_paddr = '0;
   logic [tti_pkg::VALUE_W-1:0]  csr_pwdata = '0;
   logic [tti_pkg::VALUE_W-1:0]  csr_prdata;
   logic                         csr_pready;

   // register copies and per-string scan state
   logic [tti_pkg::BASE_W-1:0]  cfg_base = '0;
   logic                        cfg_signed = 1'b1;
   logic [tti_pkg::VALUE_W-1:0] cfg_limit = tti_pkg::LIMIT_RESET;
   scan_phase_type              scan_phase;
   logic [tti_pkg::VALUE_W-1:0] acc;
   logic                        acc_neg;
   logic [tti_pkg::BASE_W-1:0]  radix;
   int unsigned                 pos;
   int unsigned                 stop_pos;
   logic [1:0]                  scan_stat;
   logic [tti_pkg::VALUE_W-1:0] quot_lim;
   logic [tti_pkg::VALUE_W-1:0] rem_lim;

   number_type                  awaited_numbers[$];
   logic [tti_pkg::CHR_W-1:0]   text_q[$];

   bit          tx_idles = 1'b1;
   bit          rx_idles = 1'b1;
   int unsigned hold_request = 0;
   int unsigned mismatches = 0;
   int unsigned results_checked = 0;
   int unsigned saturated_seen = 0;
   int unsigned bytes_sent = 0;
   int unsigned strings_sent = 0;
   int unsigned settings_used = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned cycle_count = 0;

   text_to_integer_parser #(
      .OFFSET_LIMIT(OFFSET_TOP)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_chr         (req_chr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_stop_offset (rsp_stop_offset),
      .rsp_status      (rsp_status),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // ---------------- byte scanner ----------------

   function automatic int unsigned char_digit(input logic [tti_pkg::CHR_W-1:0] c);
      if (c >= tti_pkg::CHR_ZERO && c <= tti_pkg::CHR_NINE) return c - tti_pkg::CHR_ZERO;
      if (c >= tti_pkg::CHR_UP_A && c <= tti_pkg::CHR_UP_Z) return c - tti_pkg::CHR_UP_A + 8'd10;
      if (c >= tti_pkg::CHR_LO_A && c <= tti_pkg::CHR_LO_Z) return c - tti_pkg::CHR_LO_A + 8'd10;
      return NOT_A_DIGIT;
   endfunction

   // out-of-range requests fall back to automatic
   function automatic logic [tti_pkg::BASE_W-1:0] radix_from_cfg();
      return (cfg_base >= tti_pkg::BASE_MIN && cfg_base <= tti_pkg::BASE_MAX) ? cfg_base : '0;
   endfunction

   function automatic void clear_scan();
      scan_phase = SCAN_SKIP;
      acc = '0;
      acc_neg = 1'b0;
      radix = '0;
      pos = 0;
      stop_pos = 0;
      scan_stat = tti_pkg::STAT_OK;
      quot_lim = '0;
      rem_lim = '0;
   endfunction

   function automatic void stop_scan();
      stop_pos = pos;
      scan_phase = SCAN_DONE;
   endfunction

   function automatic void lock_radix(input logic [tti_pkg::BASE_W-1:0] b);
      radix = b;
      quot_lim = cfg_limit / 64'(b);
      rem_lim = cfg_limit % 64'(b);
      scan_phase = SCAN_DIGITS;
   endfunction

   function automatic void scan_digit(input logic [tti_pkg::CHR_W-1:0] c);
      int unsigned d;
      logic [tti_pkg::VALUE_W-1:0] thr;
      d = char_digit(c);
      if (radix < tti_pkg::BASE_MIN || d >= radix) begin
         stop_scan();
         return;
      end
      // a negative number may go one past the limit
      thr = rem_lim + (acc_neg ? 64'd1 : 64'd0);
      if (acc > quot_lim || (acc == quot_lim && 64'(d) > thr)) begin
         acc = acc_neg ? ~cfg_limit : cfg_limit;
         acc_neg = 1'b0;
         scan_stat = tti_pkg::STAT_RANGE;
         stop_scan();
      end else begin
         acc = acc * 64'(radix) + 64'(d);
      end
   endfunction

   function automatic void start_number(input logic [tti_pkg::CHR_W-1:0] c);
      logic [tti_pkg::BASE_W-1:0] b;
      if (c == tti_pkg::CHR_ZERO) begin
         scan_phase = SCAN_ZERO;
      end else begin
         b = radix_from_cfg();
         lock_radix((b != 0) ? b : tti_pkg::BASE_DEC);
         scan_digit(c);
      end
   endfunction

   function automatic void scan_byte(input logic [tti_pkg::CHR_W-1:0] c);
      number_type r;
      logic [tti_pkg::BASE_W-1:0] b;
      if (c == tti_pkg::CHR_NUL) begin
         r.value = acc_neg ? 64'd0 - acc : acc;
         r.offset = (scan_phase == SCAN_DONE) ? tti_pkg::OFFSET_W'(stop_pos)
                                              : tti_pkg::OFFSET_W'(pos);
         r.status = scan_stat;
         if (scan_phase == SCAN_SKIP) begin
            r.value = '0;
            r.status = tti_pkg::STAT_BLANK;
         end
         awaited_numbers.push_back(r);
         clear_scan();
         return;
      end
      case (scan_phase)
         SCAN_SKIP: begin
            if (c != tti_pkg::CHR_SPACE && c != tti_pkg::CHR_NEWLINE) begin
               if (cfg_signed && (c == tti_pkg::CHR_PLUS || c == tti_pkg::CHR_MINUS)) begin
                  acc_neg = (c == tti_pkg::CHR_MINUS);
                  scan_phase = SCAN_SIGN;
               end else begin
                  start_number(c);
               end
            end
         end
         SCAN_SIGN: start_number(c);
         SCAN_ZERO: begin
            b = radix_from_cfg();
            if (c == tti_pkg::CHR_LO_X || c == tti_pkg::CHR_UP_X) begin
               if (b == 0 || b == tti_pkg::BASE_HEX) lock_radix(tti_pkg::BASE_HEX);
               else stop_scan();
            end else begin
               if (b == 0 || b == tti_pkg::BASE_OCT) b = tti_pkg::BASE_OCT;
               lock_radix(b);
               scan_digit(c);
            end
         end
         SCAN_DIGITS: scan_digit(c);
         default: ;
      endcase
      if (pos < OFFSET_TOP) pos++;
   endfunction

   // ---------------- string generation ----------------

   function automatic logic [tti_pkg::CHR_W-1:0] digit_char(input int unsigned d);
      if (d < 10) return tti_pkg::CHR_ZERO + 8'(d);
      return ($urandom_range(0, 1) ? tti_pkg::CHR_LO_A : tti_pkg::CHR_UP_A) + 8'(d - 10);
   endfunction

   function automatic void push_number(input logic [63:0] mag,
                                       input logic [tti_pkg::BASE_W-1:0] b);
      logic [tti_pkg::CHR_W-1:0] digits[$];
      if (mag == 0) digits.push_front(tti_pkg::CHR_ZERO);
      while (mag != 0) begin
         digits.push_front(digit_char(int'(mag % 64'(b))));
         mag = mag / 64'(b);
      end
      foreach (digits[i]) text_q.push_back(digits[i]);
   endfunction

   function automatic void push_hex_prefix();
      text_q.push_back(tti_pkg::CHR_ZERO);
      text_q.push_back($urandom_range(0, 1) ? tti_pkg::CHR_LO_X : tti_pkg::CHR_UP_X);
   endfunction

   // mostly well-formed numbers, some right at the limit, plus some noise
   function automatic void make_random_text();
      int unsigned b;
      int delta;
      logic [63:0] mag;
      text_q.delete();
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(0, 8)) text_q.push_back(8'($urandom_range(1, 255)));
      end else begin
         repeat ($urandom_range(0, 3)) begin
            text_q.push_back($urandom_range(0, 1) ? tti_pkg::CHR_SPACE : tti_pkg::CHR_NEWLINE);
         end
         case ($urandom_range(0, 3))
            0: text_q.push_back(tti_pkg::CHR_MINUS);
            1: text_q.push_back(tti_pkg::CHR_PLUS);
            default: ;
         endcase
         b = radix_from_cfg();
         if (b == 0) begin
            case ($urandom_range(0, 2))
               0: b = tti_pkg::BASE_DEC;
               1: begin
                  b = tti_pkg::BASE_OCT;
                  text_q.push_back(tti_pkg::CHR_ZERO);
               end
               default: begin
                  b = tti_pkg::BASE_HEX;
                  push_hex_prefix();
               end
            endcase
         end else if (b == tti_pkg::BASE_HEX && $urandom_range(0, 2) == 0) begin
            push_hex_prefix();
         end else if ($urandom_range(0, 3) == 0) begin
            text_q.push_back(tti_pkg::CHR_ZERO);
         end
         if ($urandom_range(0, 19) == 0) push_hex_prefix();
         case ($urandom_range(0, 3))
            0: begin
               delta = int'($urandom_range(0, 4)) - 2;
               mag = (delta < 0) ? cfg_limit - 64'(-delta) : cfg_limit + 64'(delta);
            end
            1: mag = $urandom_range(0, 1000);
            2: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: mag = {$urandom, $urandom};
         endcase
         push_number(mag, tti_pkg::BASE_W'(b));
         if (b < 36 && $urandom_range(0, 5) == 0) begin
            text_q.push_back(digit_char($urandom_range(b, 35)));
            push_number($urandom_range(0, 99), tti_pkg::BASE_W'(b));
         end
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(1, 255)));
         end
      end
      text_q.push_back(tti_pkg::CHR_NUL);
   endfunction

   // ---------------- drivers ----------------

   task automatic send_chr(input logic [tti_pkg::CHR_W-1:0] c);
      int unsigned gap;
      gap = tx_idles ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_chr <= c;
      do @(posedge clock); while (req_ready !== 1'b1);
      scan_byte(c);
      bytes_sent++;
   endtask

   task automatic send_text_q();
      foreach (text_q[i]) send_chr(text_q[i]);
      strings_sent++;
   endtask

   task automatic send_string(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      text_q.push_back(tti_pkg::CHR_NUL);
      send_text_q();
   endtask

   // let the block go idle: all results in, then the divider latency
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_numbers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_cycle(input bit wr, input logic [1:0] idx, input logic [63:0] data,
                            output logic [63:0] rd);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rd = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic verify_csr(input logic [1:0] idx);
      logic [63:0] rd;
      logic [63:0] want_v;
      case (idx)
         tti_pkg::REG_BASE:   want_v = 64'(cfg_base);
         tti_pkg::REG_SIGNED: want_v = 64'(cfg_signed);
         default:             want_v = cfg_limit;
      endcase
      csr_cycle(1'b0, idx, '0, rd);
      if (rd !== want_v) begin
         note_mismatch($sformatf("register %0d read: expected %h, got %h", idx, want_v, rd));
      end
   endtask

   task automatic put_csr(input logic [1:0] idx, input logic [63:0] data);
      logic [63:0] rd;
      csr_cycle(1'b1, idx, data, rd);
      case (idx)
         tti_pkg::REG_BASE:   cfg_base = data[tti_pkg::BASE_W-1:0];
         tti_pkg::REG_SIGNED: cfg_signed = data[0];
         default:             cfg_limit = data;
      endcase
      verify_csr(idx);
   endtask

   // unused upper bits of the narrow registers get random junk
   task automatic set_config(input logic [tti_pkg::BASE_W-1:0] b, input bit s,
                             input logic [63:0] lim);
      logic [63:0] junk;
      drain();
      junk = {$urandom, $urandom};
      put_csr(tti_pkg::REG_BASE, {junk[63:tti_pkg::BASE_W], b});
      junk = {$urandom, $urandom};
      put_csr(tti_pkg::REG_SIGNED, {junk[63:1], s});
      put_csr(tti_pkg::REG_LIMIT, lim);
      settings_used++;
   endtask

   // ---------------- result side ----------------

   initial begin : result_receiver
      int unsigned gap;
      forever begin
         if (hold_request > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end
         gap = rx_idles ? $urandom_range(0, IDLE_MAX) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready === 1'b1));
      end
   end

   always @(posedge clock) begin : result_checker
      number_type want;
      if (reset == 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (awaited_numbers.size() == 0) begin
            note_mismatch($sformatf("result with none pending: value %h offset %0d status %0d",
                                    rsp_value, rsp_stop_offset, rsp_status));
         end else begin
            want = awaited_numbers.pop_front();
            results_checked++;
            if (want.status == tti_pkg::STAT_RANGE) saturated_seen++;
            if (rsp_value !== want.value || rsp_stop_offset !== want.offset ||
                rsp_status !== want.status) begin
               note_mismatch($sformatf(
                  "result %0d: expected value %h offset %0d status %0d, got %h %0d %0d",
                  results_checked, want.value, want.offset, want.status,
                  rsp_value, rsp_stop_offset, rsp_status));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (req_valid === 1'b1 && req_ready !== 1'b1) input_stall_cycles++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------- tests ----------------

   task automatic test_register_defaults();
      verify_csr(tti_pkg::REG_BASE);
      verify_csr(tti_pkg::REG_SIGNED);
      verify_csr(tti_pkg::REG_LIMIT);
   endtask

   task automatic test_basic_strings();
      send_string("");
      send_string(" \n ");
      send_string("-");
      send_string("+0");
      send_string("  -42");
      send_string("- 5");
      send_string("0777");
      send_string("0x1F");
      send_string("0Xg");
      send_string("12a9");
      send_string("9223372036854775807");
      send_string("-9223372036854775808");
      send_string("9223372036854775808");
      send_string("-9223372036854775809");
   endtask

   task automatic test_bases();
      set_config(tti_pkg::BASE_HEX, 1'b1, tti_pkg::LIMIT_RESET);
      send_string("0x7fffffffffffffff");
      send_string("-ff");
      send_string("0x");
      set_config(tti_pkg::BASE_DEC, 1'b1, tti_pkg::LIMIT_RESET);
      send_string("0x5");
      send_string("0123");
      set_config(tti_pkg::BASE_MAX, 1'b1, tti_pkg::LIMIT_RESET);
      send_string("Zz");
      send_string("0x1");
      set_config(tti_pkg::BASE_MIN, 1'b1, tti_pkg::LIMIT_RESET);
      send_string("1012");
      set_config(tti_pkg::BASE_OCT, 1'b1, tti_pkg::LIMIT_RESET);
      send_string("0x7");
      send_string("089");
      // invalid requests act as automatic
      set_config(6'd1, 1'b1, tti_pkg::LIMIT_RESET);
      send_string("0x10");
      set_config(6'd37, 1'b1, tti_pkg::LIMIT_RESET);
      send_string("010");
      set_config(6'd63, 1'b1, tti_pkg::LIMIT_RESET);
      send_string("99");
   endtask

   task automatic test_unsigned_mode();
      set_config('0, 1'b0, ALL_ONES);
      send_string("-5");
      send_string("+5");
      send_string("18446744073709551615");
      send_string("18446744073709551616");
      send_string("0xffffffffffffffff1");
   endtask

   task automatic test_limit_extremes();
      set_config(tti_pkg::BASE_DEC, 1'b1, '0);
      send_string("0");
      send_string("1");
      send_string("-1");
      set_config('0, 1'b1, 64'd1);
      send_string("-2");
      send_string("-3");
      send_string("2");
      // signed mode with a limit past 2^63-1 wraps modulo 2^64
      set_config('0, 1'b1, ALL_ONES);
      send_string("-18446744073709551615");
      send_string("-18446744073709551616");
      set_config('0, 1'b0, 64'd1);
      send_string("1");
      send_string("2");
   endtask

   // stop offsets wider than eight bits
   task automatic test_long_string();
      set_config('0, 1'b1, tti_pkg::LIMIT_RESET);
      tx_idles = 1'b0;
      text_q.delete();
      repeat (LONG_BLANKS) text_q.push_back(tti_pkg::CHR_SPACE);
      text_q.push_back(tti_pkg::CHR_ZERO + 8'd1);
      text_q.push_back(tti_pkg::CHR_ZERO + 8'd2);
      text_q.push_back(tti_pkg::CHR_NUL);
      send_text_q();
      tx_idles = 1'b1;
   endtask

   task automatic test_output_backpressure();
      set_config('0, 1'b1, tti_pkg::LIMIT_RESET);
      tx_idles = 1'b0;
      hold_request = 600;
      repeat (12) begin
         make_random_text();
         send_text_q();
      end
      tx_idles = 1'b1;
   endtask

   task automatic test_random_strings();
      int unsigned p;
      int unsigned phase_bytes;
      logic [63:0] lim;
      logic [tti_pkg::BASE_W-1:0] b;
      bit s;
      for (p = 0; p < 9; p++) begin
         lim = {$urandom, $urandom} >> $urandom_range(0, 63);
         case (p)
            0: begin b = '0;                s = 1'b1; lim = tti_pkg::LIMIT_RESET; end
            1: begin b = tti_pkg::BASE_DEC; s = 1'b0; lim = ALL_ONES; end
            2: begin b = tti_pkg::BASE_HEX; s = 1'b1; end
            3: begin b = tti_pkg::BASE_MIN; s = 1'b0; lim = lim >> 40; end
            4: begin b = tti_pkg::BASE_MAX; s = 1'b1; lim = ALL_ONES; end
            5: begin b = tti_pkg::BASE_OCT; s = 1'b0; lim = '0; end
            6: begin b = 6'd1;              s = 1'b1; end
            7: begin b = 6'd63;             s = 1'b0; end
            default: begin
               b = tti_pkg::BASE_W'($urandom_range(0, 63));
               s = $urandom_range(0, 1);
            end
         endcase
         set_config(b, s, lim);
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            if ($urandom_range(0, 7) == 0) tx_idles = !tx_idles;
            if ($urandom_range(0, 7) == 0) rx_idles = !rx_idles;
            make_random_text();
            phase_bytes += text_q.size();
            send_text_q();
         end
      end
      tx_idles = 1'b1;
      rx_idles = 1'b1;
   endtask

   initial begin
      clear_scan();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_register_defaults();
      test_basic_strings();
      test_bases();
      test_unsigned_mode();
      test_limit_extremes();
      test_long_string();
      test_output_backpressure();
      test_random_strings();
      drain();
      $display("ran %0d strings (%0d bytes) under %0d register settings, %0d results checked",
               strings_sent, bytes_sent, settings_used, results_checked);
      $display("%0d results saturated, input held off for %0d cycles, %0d mismatches",
               saturated_seen, input_stall_cycles, mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
